// File: rtl/core/ltc_pkg.sv
// ----------------------------------------------------------------------------
// ltc_pkg
// Shared sizes, types and helpers of the line tag cache with LFU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

   // cache geometry
   localparam int ENTRIES    = 8;
   localparam int COUNT_BITS = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // fixed field widths
   localparam int TAG_BITS    = 32;
   localparam int OFFSET_BITS = 32;
   localparam int OUT_IDX_BITS = 3;

   // request codes
   localparam logic REQ_LOOKUP     = 1'b0;
   localparam logic REQ_INVALIDATE = 1'b1;

   typedef logic [IDX_BITS-1:0]    idx_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [TAG_BITS-1:0]    tag_type;
   typedef logic [OFFSET_BITS-1:0] offset_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // running result of the entry scan
   typedef struct packed {
      logic       found;
      idx_type    hit_idx;
      offset_type hit_offset;
      idx_type    victim;
      count_type  best;
   } scan_result_type;

   // entry index as shown on the result port, masked to its three bits
   function automatic logic [OUT_IDX_BITS-1:0] to_out_index(input idx_type idx);
      logic [31:0] wide;
      begin
         wide = 32'(idx);
         return wide[OUT_IDX_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ltc_scan_unit.sv
// ----------------------------------------------------------------------------
// ltc_scan_unit
// Shared compare unit: examines one entry a cycle for the first valid tag
// match and the lowest-index entry holding the smallest usage count.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_scan_unit (
   input  wire logic                    clock,
   input  wire logic                    scan_en,
   input  wire logic                    first,
   input  wire ltc_pkg::idx_type        idx,
   input  wire ltc_pkg::count_type      count,
   input  wire ltc_pkg::tag_type        tag,
   input  wire ltc_pkg::offset_type     offset,
   input  wire ltc_pkg::tag_type        line_no,
   output ltc_pkg::scan_result_type     result
);

   ltc_pkg::scan_result_type acc_ff;
   ltc_pkg::scan_result_type acc_in;
   logic                     match;

   // an entry matches when it is valid and its tag equals the line number
   assign match = (count != '0) && (tag == line_no);

   // fold the current entry into the running result
   always_comb begin
      acc_in = acc_ff;
      if (first) begin
         acc_in.found      = match;
         acc_in.hit_idx    = idx;
         acc_in.hit_offset = offset;
         acc_in.victim     = idx;
         acc_in.best       = count;
      end else begin
         if (!acc_ff.found && match) begin
            acc_in.found      = 1'b1;
            acc_in.hit_idx    = idx;
            acc_in.hit_offset = offset;
         end
         // strictly smaller only: ties keep the lower index
         if (count < acc_ff.best) begin
            acc_in.victim = idx;
            acc_in.best   = count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (scan_en) begin
         acc_ff <= acc_in;
      end
   end

   assign result = acc_ff;

endmodule

`default_nettype wire

// File: rtl/core/line_tag_cache_lfu_replace_core.sv
// ----------------------------------------------------------------------------
// line_tag_cache_lfu_replace_core
// Fully associative line tag cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req_ channel (valid/stall): a lookup carries a line
//   number and the offset to fill on a miss; an invalidate clears every
//   usage count. Each request gives exactly one response on the rsp_ channel:
//   hit flag, entry index and line offset.
//   A lookup walks the entries one per cycle through a single shared compare
//   unit, then updates the chosen entry and loads the response register in the
//   update state. An invalidate skips the scan and goes straight to the update
//   state. The next request is taken in the update state, as the previous
//   request completes.
//   req_stall is high while a scan runs, and also while the update is held
//   because the previous response still waits in the response register.
//   A stalled response holds its value. Reset clears all usage counts, so
//   every entry starts invalid; tags and offsets are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module line_tag_cache_lfu_replace_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [31:0] req_line_no,
   input  wire logic [31:0] req_fill_offset,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_hit,
   output logic [2:0]       rsp_entry_index,
   output logic [31:0]      rsp_line_offset
);

   // entry storage
   ltc_pkg::tag_type    tag_store_ff    [ltc_pkg::ENTRIES];
   ltc_pkg::offset_type offset_store_ff [ltc_pkg::ENTRIES];
   ltc_pkg::count_type  usage_count_ff  [ltc_pkg::ENTRIES];

   // sequencer
   ltc_pkg::state_type  state_ff, state_in;
   ltc_pkg::idx_type    idx_ff, idx_in;

   // latched request
   logic                req_type_ff;
   ltc_pkg::tag_type    line_ff;
   ltc_pkg::offset_type fill_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [2:0]          rsp_index_ff;
   ltc_pkg::offset_type rsp_offset_ff;

   logic                req_accept;
   logic                out_free;
   logic                scan_en;
   logic                update_go;
   logic                scan_last;
   ltc_pkg::scan_result_type scan_res;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign scan_last  = (idx_ff == ltc_pkg::IDX_BITS'(ltc_pkg::ENTRIES - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ltc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == ltc_pkg::REQ_INVALIDATE) ?
                          ltc_pkg::ST_UPDATE : ltc_pkg::ST_SCAN;
            end
         end
         ltc_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = ltc_pkg::ST_UPDATE;
            end
         end
         ltc_pkg::ST_UPDATE: begin
            if (out_free) begin
               if (req_valid) begin
                  state_in = (req_type == ltc_pkg::REQ_INVALIDATE) ?
                             ltc_pkg::ST_UPDATE : ltc_pkg::ST_SCAN;
               end else begin
                  state_in = ltc_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = ltc_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      scan_en   = 1'b0;
      update_go = 1'b0;
      case (state_ff)
         ltc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         ltc_pkg::ST_SCAN: begin
            scan_en = 1'b1;
         end
         ltc_pkg::ST_UPDATE: begin
            req_stall = !out_free;
            update_go = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // scan pointer
   always_comb begin
      idx_in = idx_ff;
      if (req_accept) begin
         idx_in = '0;
      end else if (scan_en) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ltc_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_type_ff <= req_type;
         line_ff     <= req_line_no;
         fill_ff     <= req_fill_offset;
      end
   end

   // shared compare unit, fed one entry a cycle
   ltc_scan_unit u_scan (
      .clock   (clock),
      .scan_en (scan_en),
      .first   (idx_ff == '0),
      .idx     (idx_ff),
      .count   (usage_count_ff[idx_ff]),
      .tag     (tag_store_ff[idx_ff]),
      .offset  (offset_store_ff[idx_ff]),
      .line_no (line_ff),
      .result  (scan_res)
   );

   // usage counts: reset and invalidate clear all, hit bumps, fill sets one
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ltc_pkg::ENTRIES; i++) begin
            usage_count_ff[i] <= '0;
         end
      end else if (update_go) begin
         if (req_type_ff == ltc_pkg::REQ_INVALIDATE) begin
            for (int i = 0; i < ltc_pkg::ENTRIES; i++) begin
               usage_count_ff[i] <= '0;
            end
         end else if (scan_res.found) begin
            if (usage_count_ff[scan_res.hit_idx] != '1) begin
               usage_count_ff[scan_res.hit_idx] <=
                  usage_count_ff[scan_res.hit_idx] + 1'b1;
            end
         end else begin
            usage_count_ff[scan_res.victim] <= ltc_pkg::COUNT_BITS'(1);
         end
      end
   end

   // tag and offset refill of the victim on a miss
   always_ff @(posedge clock) begin
      if (update_go && (req_type_ff == ltc_pkg::REQ_LOOKUP) && !scan_res.found) begin
         tag_store_ff[scan_res.victim]    <= line_ff;
         offset_store_ff[scan_res.victim] <= fill_ff;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (update_go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update_go) begin
         if (req_type_ff == ltc_pkg::REQ_INVALIDATE) begin
            rsp_hit_ff    <= 1'b0;
            rsp_index_ff  <= '0;
            rsp_offset_ff <= '0;
         end else if (scan_res.found) begin
            rsp_hit_ff    <= 1'b1;
            rsp_index_ff  <= ltc_pkg::to_out_index(scan_res.hit_idx);
            rsp_offset_ff <= scan_res.hit_offset;
         end else begin
            rsp_hit_ff    <= 1'b0;
            rsp_index_ff  <= ltc_pkg::to_out_index(scan_res.victim);
            rsp_offset_ff <= fill_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_line_offset = rsp_offset_ff;

endmodule

`default_nettype wire

// File: rtl/core/ltc_checker.sv
// ----------------------------------------------------------------------------
// ltc_checker
// Port-level checks of the line tag cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ltc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_hit,
   input wire logic [2:0]  rsp_entry_index,
   input wire logic [31:0] rsp_line_offset
);

   // no response is pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         ($stable(rsp_hit) && $stable(rsp_entry_index) && $stable(rsp_line_offset)))
      else $error("stalled response changed");

   // an accepted lookup starts a scan, so the next request waits
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == ltc_pkg::REQ_LOOKUP)) |=> req_stall)
      else $error("request taken during a scan");

endmodule

bind line_tag_cache_lfu_replace_core ltc_checker u_ltc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_entry_index (rsp_entry_index),
   .rsp_line_offset (rsp_line_offset)
);

`default_nettype wire
